// ===== design/apwc_pkg.sv =====
// Shared constants and types for the adaptive penalty window controller.
// No dependencies; the top level and its checker use it by scoped names.
`default_nettype none

package apwc_pkg;

  // opcodes of an input beat
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_ADJUST = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_INCREASE = 3'd1;
  localparam logic [2:0] REG_DECREASE = 3'd2;
  localparam logic [2:0] REG_INIT_CAP = 3'd3;
  localparam logic [2:0] REG_INIT_DUR = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;
  localparam int PEN_W      = 33;   // penalty width at the ports, Q17.16
  localparam int PEN_ST_W   = 64;   // stored penalty, decrease may grow it past 33 bits
  localparam int CNT_OUT_W  = 8;

  // Q0.16 margin 0.05, Q17.16 cap 100000.0 and floor 0.1
  localparam int          MARGIN_Q16 = 3277;
  localparam logic [32:0] PEN_CAP    = 33'd6553600000;
  localparam logic [32:0] PEN_FLOOR  = 33'd6554;

  // register reset values
  localparam logic [16:0] TARGET_RST   = 17'd13107;
  localparam logic [17:0] INCREASE_RST = 18'd78643;
  localparam logic [16:0] DECREASE_RST = 17'd55706;
  localparam logic [32:0] PEN_RST      = 33'd65536;

  typedef struct packed {
    logic [PEN_W-1:0]     cap_pen;
    logic [PEN_W-1:0]     dur_pen;
    logic [CNT_OUT_W-1:0] load_cnt;
    logic [CNT_OUT_W-1:0] dur_cnt;
  } res_t;

endpackage

`default_nettype wire

// ===== design/adaptive_penalty_window_controller.sv =====
// Adaptive penalty window controller: flag windows in a ring memory, penalty update.
// Depends on apwc_pkg.
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready): one beat carries opcode, load_ok and
//   duration_ok. Record pushes the flag pair into both windows over the oldest
//   pair; adjust scales each penalty per the window's feasible fraction; load
//   copies the initial penalties from the registers; opcode 3 changes nothing.
//   Output channel (out_valid/out_ready): one beat per input beat, carrying the
//   two penalties (low 33 bits) and the two window counts (low 8 bits) as they
//   stand after that item.
//   Throughput: one item per cycle while in_ready is high, any mix of opcodes.
//   Set by the penalty loop: adjust does compare, multiply and clamp in the
//   cycle it is accepted. The windows sit in one WINDOW x 2 memory; the slot
//   under the ring pointer is read ahead, so records keep the full rate.
//   Stall: an output register plus one skid entry; in_ready drops only while
//   both hold results the receiver has not taken.
//   Reset: registers take their reset values, counts go to WINDOW, penalties
//   to 1.0. The memory is not cleared: slots not yet written in the first lap
//   of the pointer read as ones, so no clearing pass is needed. Configuration
//   (cfg_we/cfg_index/cfg_data) is the user's to write only while idle; unenforced.
module adaptive_penalty_window_controller #(
  parameter int WINDOW = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [apwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [apwc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         opcode,
  input  wire logic                               load_ok,
  input  wire logic                               duration_ok,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [apwc_pkg::PEN_W-1:0]              capacity_penalty_out,
  output logic [apwc_pkg::PEN_W-1:0]              duration_penalty_out,
  output logic [apwc_pkg::CNT_OUT_W-1:0]          load_ok_count,
  output logic [apwc_pkg::CNT_OUT_W-1:0]          duration_ok_count
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int EXT_W = CNT_W + apwc_pkg::CNT_OUT_W;
  localparam int CMP_W = CNT_W + 34;
  localparam int PW    = apwc_pkg::PEN_ST_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
  localparam logic signed [CMP_W-1:0] MARGIN_S = CMP_W'(apwc_pkg::MARGIN_Q16);
  localparam logic signed [CMP_W-1:0] WINDOW_S = CMP_W'(WINDOW);

  // configuration registers
  logic [16:0] target_feasible;
  logic [17:0] increase_factor;
  logic [16:0] decrease_factor;
  logic [32:0] init_cap_pen;
  logic [32:0] init_dur_pen;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_feasible <= apwc_pkg::TARGET_RST;
      increase_factor <= apwc_pkg::INCREASE_RST;
      decrease_factor <= apwc_pkg::DECREASE_RST;
      init_cap_pen    <= apwc_pkg::PEN_RST;
      init_dur_pen    <= apwc_pkg::PEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        apwc_pkg::REG_TARGET:   target_feasible <= cfg_data[16:0];
        apwc_pkg::REG_INCREASE: increase_factor <= cfg_data[17:0];
        apwc_pkg::REG_DECREASE: decrease_factor <= cfg_data[16:0];
        apwc_pkg::REG_INIT_CAP: init_cap_pen    <= cfg_data;
        apwc_pkg::REG_INIT_DUR: init_dur_pen    <= cfg_data;
        default: ;
      endcase
    end
  end

  // block state
  logic [PTR_W-1:0] ptr, ptr_next;
  logic             wrapped, wrapped_next;   // pointer has completed one lap
  logic [CNT_W-1:0] load_count, load_count_next;
  logic [CNT_W-1:0] dur_count, dur_count_next;
  logic [PW-1:0]    cap_pen, cap_pen_next;
  logic [PW-1:0]    dur_pen, dur_pen_next;

  logic accept;
  logic is_record;
  assign accept    = in_valid && in_ready;
  assign is_record = accept && (opcode == apwc_pkg::OP_RECORD);

  // window memory: bit 0 load flag, bit 1 duration flag
  logic [1:0]       win_mem [WINDOW];
  logic [1:0]       rd_data;
  logic [1:0]       wr_data;
  logic             fwd_hit;
  logic [1:0]       fwd_data;
  logic [1:0]       old_flags;

  assign wr_data = {duration_ok, load_ok};

  // read slot of the next pointer value, so the oldest pair is ready next cycle
  always_ff @(posedge clk) begin
    if (is_record) begin
      win_mem[ptr] <= wr_data;
    end
    rd_data  <= win_mem[ptr_next];
    fwd_hit  <= is_record && (ptr_next == ptr);
    fwd_data <= wr_data;
  end

  always_comb begin
    if (!wrapped) begin
      old_flags = 2'b11;
    end else if (fwd_hit) begin
      old_flags = fwd_data;
    end else begin
      old_flags = rd_data;
    end
  end

  // fraction tests, exact: count*65536 against (target -/+ margin)*WINDOW
  logic signed [CMP_W-1:0] tgt_s, lo_bound, hi_bound, load_lhs, dur_lhs;
  logic load_few, load_many, dur_few, dur_many;

  always_comb begin
    tgt_s     = $signed(CMP_W'(target_feasible));
    lo_bound  = (tgt_s - MARGIN_S) * WINDOW_S;
    hi_bound  = (tgt_s + MARGIN_S) * WINDOW_S;
    load_lhs  = $signed(CMP_W'({load_count, 16'b0}));
    dur_lhs   = $signed(CMP_W'({dur_count, 16'b0}));
    load_few  = load_lhs < lo_bound;
    load_many = load_lhs > hi_bound;
    dur_few   = dur_lhs < lo_bound;
    dur_many  = dur_lhs > hi_bound;
  end

  // one shared multiplier per penalty, product kept modulo 2^64
  function automatic logic [PW-1:0] adjust_pen(
    input logic [PW-1:0] pen,
    input logic          few,
    input logic          many,
    input logic [17:0]   inc,
    input logic [16:0]   dec
  );
    logic [17:0]   fac;
    logic [49:0]   pp_lo;
    logic [49:0]   pp_hi;
    logic [PW-1:0] prod;
    logic [47:0]   p;
    logic [PW-1:0] res;
    fac   = few ? inc : {1'b0, dec};
    pp_lo = 50'(pen[31:0]) * 50'(fac);
    pp_hi = 50'(pen[63:32]) * 50'(fac);
    prod  = PW'(pp_lo) + {pp_hi[31:0], 32'b0};
    p     = prod[63:16];
    res   = pen;
    if (few && (pen < PW'(apwc_pkg::PEN_CAP))) begin
      res = (p > 48'(apwc_pkg::PEN_CAP)) ? PW'(apwc_pkg::PEN_CAP) : PW'(p);
    end else if (many && (pen > PW'(apwc_pkg::PEN_FLOOR))) begin
      res = (p < 48'(apwc_pkg::PEN_FLOOR)) ? PW'(apwc_pkg::PEN_FLOOR) : PW'(p);
    end
    return res;
  endfunction

  always_comb begin
    ptr_next        = ptr;
    wrapped_next    = wrapped;
    load_count_next = load_count;
    dur_count_next  = dur_count;
    cap_pen_next    = cap_pen;
    dur_pen_next    = dur_pen;
    if (accept) begin
      case (opcode)
        apwc_pkg::OP_RECORD: begin
          load_count_next = load_count - CNT_W'(old_flags[0]) + CNT_W'(load_ok);
          dur_count_next  = dur_count - CNT_W'(old_flags[1]) + CNT_W'(duration_ok);
          if (ptr == PTR_LAST) begin
            ptr_next     = '0;
            wrapped_next = 1'b1;
          end else begin
            ptr_next = ptr + PTR_W'(1);
          end
        end
        apwc_pkg::OP_ADJUST: begin
          cap_pen_next = adjust_pen(cap_pen, load_few, load_many,
                                    increase_factor, decrease_factor);
          dur_pen_next = adjust_pen(dur_pen, dur_few, dur_many,
                                    increase_factor, decrease_factor);
        end
        apwc_pkg::OP_LOAD: begin
          cap_pen_next = PW'(init_cap_pen);
          dur_pen_next = PW'(init_dur_pen);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      wrapped    <= 1'b0;
      load_count <= CNT_FULL;
      dur_count  <= CNT_FULL;
      cap_pen    <= PW'(apwc_pkg::PEN_RST);
      dur_pen    <= PW'(apwc_pkg::PEN_RST);
    end else begin
      ptr        <= ptr_next;
      wrapped    <= wrapped_next;
      load_count <= load_count_next;
      dur_count  <= dur_count_next;
      cap_pen    <= cap_pen_next;
      dur_pen    <= dur_pen_next;
    end
  end

  // result of this beat: state after the step
  apwc_pkg::res_t res_new;
  logic [EXT_W-1:0] load_ext, dur_ext;

  always_comb begin
    load_ext         = EXT_W'(load_count_next);
    dur_ext          = EXT_W'(dur_count_next);
    res_new.cap_pen  = cap_pen_next[apwc_pkg::PEN_W-1:0];
    res_new.dur_pen  = dur_pen_next[apwc_pkg::PEN_W-1:0];
    res_new.load_cnt = load_ext[apwc_pkg::CNT_OUT_W-1:0];
    res_new.dur_cnt  = dur_ext[apwc_pkg::CNT_OUT_W-1:0];
  end

  // output register and skid entry
  apwc_pkg::res_t out_res, skid_res;
  logic           skid_valid;
  logic           out_free;

  assign in_ready = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_free) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_free) begin
        out_res <= res_new;
      end else begin
        skid_res <= res_new;
      end
    end else if (out_free && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign capacity_penalty_out = out_res.cap_pen;
  assign duration_penalty_out = out_res.dur_pen;
  assign load_ok_count        = out_res.load_cnt;
  assign duration_ok_count    = out_res.dur_cnt;

endmodule

`default_nettype wire

// ===== design/apwc_checker.sv =====
// Port-level checks for the adaptive penalty window controller, with its bind.
// Depends on apwc_pkg and on the top level's port list.
`default_nettype none

module apwc_port_checks #(
  parameter int WINDOW = 128
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [apwc_pkg::PEN_W-1:0]    capacity_penalty_out,
  input wire logic [apwc_pkg::PEN_W-1:0]    duration_penalty_out,
  input wire logic [apwc_pkg::CNT_OUT_W-1:0] load_ok_count,
  input wire logic [apwc_pkg::CNT_OUT_W-1:0] duration_ok_count
);

  localparam logic CNT_FITS = (WINDOW < 256);
  localparam logic [apwc_pkg::CNT_OUT_W-1:0] CNT_MAX = apwc_pkg::CNT_OUT_W'(WINDOW);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(capacity_penalty_out)
      && $stable(duration_penalty_out) && $stable(load_ok_count)
      && $stable(duration_ok_count))
    else $error("stalled output beat changed");

  // nothing is shown out of reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output valid or input blocked after reset");

  // input is blocked only while results are waiting
  a_block_needs_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input blocked with empty output");

  // after an accepted beat a result is always valid on the next cycle
  a_beat_shows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // window counts never pass the window size (checked while it fits in 8 bits)
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && CNT_FITS |-> (load_ok_count <= CNT_MAX)
      && (duration_ok_count <= CNT_MAX))
    else $error("window count above window size");

endmodule

bind adaptive_penalty_window_controller apwc_port_checks #(.WINDOW(WINDOW)) u_apwc_checker (
  .clk                  (clk),
  .rst                  (rst),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .capacity_penalty_out (capacity_penalty_out),
  .duration_penalty_out (duration_penalty_out),
  .load_ok_count        (load_ok_count),
  .duration_ok_count    (duration_ok_count)
);

`default_nettype wire

// ===== tb/sv/apwc_checker.sv =====
// Checker for the adaptive penalty window controller: keeps its own copy of the
// flag windows and penalties, predicts each result beat and compares it.
// Depends on apwc_pkg.
`default_nettype none

module apwc_checker #(
  parameter int WINDOW = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [apwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [apwc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [1:0]                      opcode,
  input  wire logic                            load_ok,
  input  wire logic                            duration_ok,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [apwc_pkg::PEN_W-1:0]      capacity_penalty_out,
  input  wire logic [apwc_pkg::PEN_W-1:0]      duration_penalty_out,
  input  wire logic [apwc_pkg::CNT_OUT_W-1:0]  load_ok_count,
  input  wire logic [apwc_pkg::CNT_OUT_W-1:0]  duration_ok_count,
  output int                                   fail_count,
  output int                                   expect_depth
);

  localparam int PEND_DEPTH = 8;   // the block holds at most two results

  // register copies
  logic [16:0] target_q;
  logic [17:0] raise_q;
  logic [16:0] lower_q;
  logic [32:0] init_cap_q;
  logic [32:0] init_dur_q;

  // window and penalty copies
  logic [WINDOW-1:0] load_flags;
  logic [WINDOW-1:0] dur_flags;
  int                ring_slot;
  int                load_ones;
  int                dur_ones;
  logic [63:0]       cap_pen;
  logic [63:0]       dur_pen;

  // predicted beats waiting for their result, oldest at head_idx
  apwc_pkg::res_t    pending_res [PEND_DEPTH];
  int                head_idx;
  int                tail_idx;
  int                pending_cnt;

  initial begin
    fail_count   = 0;
    expect_depth = 0;
    head_idx     = 0;
    tail_idx     = 0;
    pending_cnt  = 0;
  end

  task automatic note_error(input string msg);
    fail_count++;
    $display("apwc_checker: %s (t=%0t)", msg, $time);
  endtask

  // one penalty step against its window count; products wrap at 64 bits
  function automatic logic [63:0] scale_penalty(input logic [63:0] pen, input int ones);
    longint      seen;
    longint      low_edge;
    longint      high_edge;
    logic [63:0] prod;
    seen      = longint'(ones) * 65536;
    low_edge  = (longint'(target_q) - apwc_pkg::MARGIN_Q16) * WINDOW;
    high_edge = (longint'(target_q) + apwc_pkg::MARGIN_Q16) * WINDOW;
    if (seen < low_edge && pen < 64'(apwc_pkg::PEN_CAP)) begin
      prod = (pen * 64'(raise_q)) >> 16;
      return (prod > 64'(apwc_pkg::PEN_CAP)) ? 64'(apwc_pkg::PEN_CAP) : prod;
    end
    if (seen > high_edge && pen > 64'(apwc_pkg::PEN_FLOOR)) begin
      prod = (pen * 64'(lower_q)) >> 16;
      return (prod < 64'(apwc_pkg::PEN_FLOOR)) ? 64'(apwc_pkg::PEN_FLOOR) : prod;
    end
    return pen;
  endfunction

  task automatic predict_penalties(input logic [1:0] op, input logic lf, input logic df);
    apwc_pkg::res_t res;
    case (op)
      apwc_pkg::OP_RECORD: begin
        load_ones = load_ones - int'(load_flags[ring_slot]) + int'(lf);
        dur_ones  = dur_ones - int'(dur_flags[ring_slot]) + int'(df);
        load_flags[ring_slot] = lf;
        dur_flags[ring_slot]  = df;
        ring_slot = (ring_slot + 1) % WINDOW;
      end
      apwc_pkg::OP_ADJUST: begin
        cap_pen = scale_penalty(cap_pen, load_ones);
        dur_pen = scale_penalty(dur_pen, dur_ones);
      end
      apwc_pkg::OP_LOAD: begin
        cap_pen = 64'(init_cap_q);
        dur_pen = 64'(init_dur_q);
      end
      default: ;
    endcase
    res.cap_pen  = cap_pen[32:0];
    res.dur_pen  = dur_pen[32:0];
    res.load_cnt = 8'(load_ones);
    res.dur_cnt  = 8'(dur_ones);
    if (pending_cnt == PEND_DEPTH) begin
      note_error("too many result beats pending");
    end else begin
      pending_res[tail_idx] = res;
      tail_idx = (tail_idx + 1) % PEND_DEPTH;
      pending_cnt++;
    end
  endtask

  task automatic compare_result();
    apwc_pkg::res_t want;
    if (pending_cnt == 0) begin
      note_error("result beat with no item pending");
      return;
    end
    want = pending_res[head_idx];
    head_idx = (head_idx + 1) % PEND_DEPTH;
    pending_cnt--;
    if (capacity_penalty_out !== want.cap_pen)
      note_error($sformatf("capacity_penalty_out got %0d want %0d",
                           capacity_penalty_out, want.cap_pen));
    if (duration_penalty_out !== want.dur_pen)
      note_error($sformatf("duration_penalty_out got %0d want %0d",
                           duration_penalty_out, want.dur_pen));
    if (load_ok_count !== want.load_cnt)
      note_error($sformatf("load_ok_count got %0d want %0d", load_ok_count, want.load_cnt));
    if (duration_ok_count !== want.dur_cnt)
      note_error($sformatf("duration_ok_count got %0d want %0d",
                           duration_ok_count, want.dur_cnt));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      target_q    = apwc_pkg::TARGET_RST;
      raise_q     = apwc_pkg::INCREASE_RST;
      lower_q     = apwc_pkg::DECREASE_RST;
      init_cap_q  = apwc_pkg::PEN_RST;
      init_dur_q  = apwc_pkg::PEN_RST;
      load_flags  = '1;
      dur_flags   = '1;
      ring_slot   = 0;
      load_ones   = WINDOW;
      dur_ones    = WINDOW;
      cap_pen     = 64'(apwc_pkg::PEN_RST);
      dur_pen     = 64'(apwc_pkg::PEN_RST);
      head_idx    = 0;
      tail_idx    = 0;
      pending_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          apwc_pkg::REG_TARGET:   target_q   = cfg_data[16:0];
          apwc_pkg::REG_INCREASE: raise_q    = cfg_data[17:0];
          apwc_pkg::REG_DECREASE: lower_q    = cfg_data[16:0];
          apwc_pkg::REG_INIT_CAP: init_cap_q = cfg_data[32:0];
          apwc_pkg::REG_INIT_DUR: init_dur_q = cfg_data[32:0];
          default: ;
        endcase
      end
      // results are registered and leave after their item, so compare before predicting
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) predict_penalties(opcode, load_ok, duration_ok);
    end
    expect_depth = pending_cnt;
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench top for the adaptive penalty window controller: clock, reset,
// register writes, input beats and receiver back-pressure, plus the verdict.
// Depends on apwc_pkg, adaptive_penalty_window_controller and apwc_checker.
`default_nettype none

module tb;

  localparam int         WINDOW      = 128;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED   = 2'd3;   // reserved opcode, must be a no-op

  // flag densities used per burst: 0 and 100 drain or fill a window
  localparam int FLAG_BIAS [5] = '{0, 10, 50, 90, 100};

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} pace_t;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            cfg_we      = 1'b0;
  logic [apwc_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [apwc_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                            in_valid    = 1'b0;
  logic                            in_ready;
  logic [1:0]                      opcode      = apwc_pkg::OP_RECORD;
  logic                            load_ok     = 1'b0;
  logic                            duration_ok = 1'b0;
  logic                            out_valid;
  logic                            out_ready   = 1'b0;
  logic [apwc_pkg::PEN_W-1:0]      capacity_penalty_out;
  logic [apwc_pkg::PEN_W-1:0]      duration_penalty_out;
  logic [apwc_pkg::CNT_OUT_W-1:0]  load_ok_count;
  logic [apwc_pkg::CNT_OUT_W-1:0]  duration_ok_count;

  int fail_count;
  int expect_depth;
  int cycles       = 0;
  int tx_idle_pct  = 0;   // chance per cycle that the sender holds back
  int rx_stall_pct = 0;   // chance per cycle that the receiver stalls

  always #4 clk = ~clk;

  adaptive_penalty_window_controller #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .opcode              (opcode),
    .load_ok             (load_ok),
    .duration_ok         (duration_ok),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .capacity_penalty_out(capacity_penalty_out),
    .duration_penalty_out(duration_penalty_out),
    .load_ok_count       (load_ok_count),
    .duration_ok_count   (duration_ok_count)
  );

  apwc_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .opcode              (opcode),
    .load_ok             (load_ok),
    .duration_ok         (duration_ok),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .capacity_penalty_out(capacity_penalty_out),
    .duration_penalty_out(duration_penalty_out),
    .load_ok_count       (load_ok_count),
    .duration_ok_count   (duration_ok_count),
    .fail_count          (fail_count),
    .expect_depth        (expect_depth)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver: one ready decision per cycle, made at the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // One input beat. Idle cycles come first, then valid rises with the payload
  // and holds until the beat is taken. Each falling edge sees a single
  // assignment to in_valid, so back-to-back beats keep valid high.
  task automatic send_item(input logic [1:0] op, input logic lf, input logic df);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    load_ok     <= lf;
    duration_ok <= df;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, let every pending result drain, then leave slack for the output
  // stage (the output register plus the skid entry).
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expect_depth != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [apwc_pkg::CFG_IDX_W-1:0] idx, input longint value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= apwc_pkg::CFG_DATA_W'(value);
  endtask

  // Full register set, written only once the block has gone quiet.
  task automatic apply_settings(input longint target, input longint raise, input longint lower,
                                input longint init_cap, input longint init_dur);
    wait_idle();
    write_reg(apwc_pkg::REG_TARGET, target);
    write_reg(apwc_pkg::REG_INCREASE, raise);
    write_reg(apwc_pkg::REG_DECREASE, lower);
    write_reg(apwc_pkg::REG_INIT_CAP, init_cap);
    write_reg(apwc_pkg::REG_INIT_DUR, init_dur);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Legal initial penalty anywhere between the floor and the cap.
  function automatic longint pick_penalty();
    longint unsigned span;
    longint unsigned raw;
    span = 64'(apwc_pkg::PEN_CAP) - 64'(apwc_pkg::PEN_FLOOR) + 1;
    raw  = {$urandom, $urandom};
    return longint'(64'(apwc_pkg::PEN_FLOOR) + raw % span);
  endfunction

  // Random traffic in bursts. Each burst picks its own pacing, flag densities
  // and op mix; long record-heavy bursts push the windows all the way to empty
  // or full so that adjusts hit both the cap and the floor.
  task automatic run_random(input int n_items);
    int    left;
    int    burst;
    int    load_bias;
    int    dur_bias;
    int    rec_pct;
    int    pick;
    pace_t pace;
    logic [1:0] op;
    left = n_items;
    while (left > 0) begin
      pace = pace_t'($urandom_range(3));
      case (pace)
        IDLE_NONE: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        IDLE_SEND: begin
          tx_idle_pct  = 58;
          rx_stall_pct = 0;
        end
        IDLE_RECV: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 58;
        end
        default: begin
          tx_idle_pct  = 30;
          rx_stall_pct = 30;
        end
      endcase
      load_bias = FLAG_BIAS[$urandom_range(4)];
      dur_bias  = FLAG_BIAS[$urandom_range(4)];
      rec_pct   = $urandom_range(1) ? 90 : 50;
      burst     = ($urandom_range(9) < 7) ? $urandom_range(40, 4) : $urandom_range(160, 100);
      if (burst > left) burst = left;
      repeat (burst) begin
        pick = $urandom_range(99);
        if (pick < rec_pct) begin
          op = apwc_pkg::OP_RECORD;
        end else begin
          pick = $urandom_range(9);
          op = (pick < 8) ? apwc_pkg::OP_ADJUST : (pick == 8) ? apwc_pkg::OP_LOAD : OP_UNUSED;
        end
        send_item(op, $urandom_range(99) < load_bias, $urandom_range(99) < dur_bias);
      end
      left -= burst;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset register values, no idling: every opcode, every
    // flag combination, the reserved opcode as a no-op.
    send_item(apwc_pkg::OP_LOAD,   1'b0, 1'b0);
    send_item(OP_UNUSED,           1'b1, 1'b1);
    send_item(apwc_pkg::OP_RECORD, 1'b1, 1'b1);
    send_item(apwc_pkg::OP_RECORD, 1'b0, 1'b0);
    send_item(apwc_pkg::OP_RECORD, 1'b1, 1'b0);
    send_item(apwc_pkg::OP_RECORD, 1'b0, 1'b1);
    // windows nearly full against a 0.2 target: both penalties step down
    send_item(apwc_pkg::OP_ADJUST, 1'b0, 1'b0);
    send_item(apwc_pkg::OP_ADJUST, 1'b1, 1'b1);
    send_item(apwc_pkg::OP_ADJUST, 1'b0, 1'b1);
    send_item(apwc_pkg::OP_LOAD,   1'b1, 1'b0);
    send_item(OP_UNUSED,           1'b0, 1'b0);

    // Initial penalties outside the legal range are loaded unclamped: one
    // above the cap (then floored by a zero decrease), one below the floor
    // (left alone since it is not above the floor).
    apply_settings(0, 262143, 0, 64'h1_FFFF_FFFF, 0);
    send_item(apwc_pkg::OP_LOAD,   1'b0, 1'b0);
    send_item(OP_UNUSED,           1'b0, 1'b0);
    send_item(apwc_pkg::OP_ADJUST, 1'b0, 1'b0);
    send_item(apwc_pkg::OP_ADJUST, 1'b1, 1'b1);
    send_item(apwc_pkg::OP_LOAD,   1'b1, 1'b1);
    send_item(apwc_pkg::OP_RECORD, 1'b0, 1'b0);
    send_item(apwc_pkg::OP_ADJUST, 1'b0, 1'b0);

    // Random phases across register extremes and random settings.
    apply_settings(65536, 262143, 65536, 64'(apwc_pkg::PEN_CAP), 64'(apwc_pkg::PEN_FLOOR));
    run_random(180);
    apply_settings(0, 65536, 0, 64'(apwc_pkg::PEN_FLOOR), 64'(apwc_pkg::PEN_CAP));
    run_random(180);
    apply_settings($urandom_range(65536, 0), $urandom_range(262143, 65536),
                   $urandom_range(65536, 0), pick_penalty(), pick_penalty());
    run_random(180);
    apply_settings($urandom_range(65536, 0), $urandom_range(262143, 65536),
                   $urandom_range(65536, 0), pick_penalty(), pick_penalty());
    run_random(180);
    apply_settings(apwc_pkg::TARGET_RST, apwc_pkg::INCREASE_RST, apwc_pkg::DECREASE_RST,
                   64'(apwc_pkg::PEN_RST), 64'(apwc_pkg::PEN_RST));
    run_random(180);

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== adaptive_penalty_window_controller.f =====
design/apwc_pkg.sv
design/adaptive_penalty_window_controller.sv
design/apwc_checker.sv
tb/sv/apwc_checker.sv
tb/sv/tb.sv
